### rtl/gbscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbscr_pkg
// Shared types and constants of the GPIO bank set/clear register block.
// ----------------------------------------------------------------------------
package gbscr_pkg;

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 14;
    localparam int BANK_NUM_W = 6;   // widest bank number (legacy stride)
    localparam int OFF_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_REGS   = 6;

    // opcode field
    localparam logic OPC_READ  = 1'b0;
    localparam logic OPC_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_STRIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULL_PRESENT = 2'd1;

    // register base offsets, address bits [11:4]
    localparam logic [7:0] BASE_INT     = 8'h01;
    localparam logic [7:0] BASE_MASK    = 8'h02;
    localparam logic [7:0] BASE_PAT1    = 8'h03;
    localparam logic [7:0] BASE_PAT0    = 8'h04;
    localparam logic [7:0] BASE_PULL_UP = 8'h11;
    localparam logic [7:0] BASE_PULL_DN = 8'h12;

    // alias within a register slot, address bits [3:0]
    localparam logic [3:0] ALIAS_READ  = 4'h0;
    localparam logic [3:0] ALIAS_SET   = 4'h4;
    localparam logic [3:0] ALIAS_CLEAR = 4'h8;

    typedef enum logic [2:0] {
        REG_INT     = 3'd0,
        REG_MASK    = 3'd1,
        REG_PAT1    = 3'd2,
        REG_PAT0    = 3'd3,
        REG_PULL_UP = 3'd4,
        REG_PULL_DN = 3'd5
    } t_reg_sel;

    typedef enum logic [2:0] {
        OP_BAD,
        OP_READ_PADS,
        OP_READ_REG,
        OP_SET,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                   op;
        t_reg_sel              sel;
        logic [BANK_NUM_W-1:0] bank;
        logic                  oor;
    } t_dec;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_address;
        logic [1:0]        bank_index;
        logic [DATA_W-1:0] output_enable_mask;
        logic [DATA_W-1:0] output_level_mask;
        logic [DATA_W-1:0] device_mode_mask;
        logic [DATA_W-1:0] interrupt_mode_mask;
        logic [DATA_W-1:0] pull_up_mask;
        logic [DATA_W-1:0] pull_down_mask;
    } t_rsp;

endpackage

### rtl/gbscr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbscr interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbscr_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [13:0] address;
    logic [31:0] write_data;
    logic [31:0] pad_levels;

    modport source (output valid, opcode, address, write_data, pad_levels, input ready);
    modport sink   (input valid, opcode, address, write_data, pad_levels, output ready);
endinterface

interface gbscr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        bad_address;
    logic [1:0]  bank_index;
    logic [31:0] output_enable_mask;
    logic [31:0] output_level_mask;
    logic [31:0] device_mode_mask;
    logic [31:0] interrupt_mode_mask;
    logic [31:0] pull_up_mask;
    logic [31:0] pull_down_mask;

    modport source (output valid, read_data, bad_address, bank_index, output_enable_mask,
                    output_level_mask, device_mode_mask, interrupt_mode_mask,
                    pull_up_mask, pull_down_mask, input ready);
    modport sink   (input valid, read_data, bad_address, bank_index, output_enable_mask,
                    output_level_mask, device_mode_mask, interrupt_mode_mask,
                    pull_up_mask, pull_down_mask, output ready);
endinterface

interface gbscr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

### rtl/gbscr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbscr_decode
// Splits a bus address into bank and offset and classifies the access.
// ----------------------------------------------------------------------------
module gbscr_decode #(
    parameter int NUM_BANKS = 4
) (
    input  logic                  i_opcode,
    input  logic [13:0]           i_address,
    input  logic                  i_wide_stride,
    input  logic                  i_pull_present,
    output gbscr_pkg::t_dec       o_dec
);
    import gbscr_pkg::*;

    logic [BANK_NUM_W-1:0] bank;
    logic [OFF_W-1:0]      off;
    logic [7:0]            base;
    logic [3:0]            alias_sel;
    logic                  hit;
    t_reg_sel              sel;
    logic                  oor;

    always_comb begin
        if (i_wide_stride) begin
            bank = BANK_NUM_W'(i_address[13:12]);
            off  = i_address[11:0];
        end else begin
            bank = i_address[13:8];
            off  = OFF_W'(i_address[7:0]);
        end
        base      = off[11:4];
        alias_sel = off[3:0];
        oor       = bank >= BANK_NUM_W'(NUM_BANKS);
    end

    // legacy stride keeps base below 0x10, so the pull slots never match there
    always_comb begin
        hit = 1'b1;
        sel = REG_INT;
        case (base)
            BASE_INT:     sel = REG_INT;
            BASE_MASK:    sel = REG_MASK;
            BASE_PAT1:    sel = REG_PAT1;
            BASE_PAT0:    sel = REG_PAT0;
            BASE_PULL_UP: begin
                sel = REG_PULL_UP;
                hit = i_pull_present;
            end
            BASE_PULL_DN: begin
                sel = REG_PULL_DN;
                hit = i_pull_present;
            end
            default:      hit = 1'b0;
        endcase
    end

    always_comb begin
        o_dec.sel  = sel;
        o_dec.bank = bank;
        o_dec.oor  = oor;
        if (oor) begin
            o_dec.op = OP_BAD;
        end else if (off == '0) begin
            o_dec.op = (i_opcode == OPC_WRITE) ? OP_BAD : OP_READ_PADS;
        end else if (!hit) begin
            o_dec.op = OP_BAD;
        end else if (i_opcode == OPC_READ) begin
            o_dec.op = (alias_sel == ALIAS_READ) ? OP_READ_REG : OP_BAD;
        end else if (alias_sel == ALIAS_SET) begin
            o_dec.op = OP_SET;
        end else if (alias_sel == ALIAS_CLEAR) begin
            o_dec.op = OP_CLEAR;
        end else begin
            o_dec.op = OP_BAD;
        end
    end

endmodule

### rtl/gpio_bank_set_clear_registers_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_bank_set_clear_registers_top
// Multi-bank pin mode register block with set/clear aliases.
// ----------------------------------------------------------------------------
// Takes one bus access per cycle while the response side is ready and returns
// one response per access. Decode of the address and the read of the bank's
// entry from the bank memory come first, into the stage 1 registers; then the
// set or clear is applied, the entry written back and the response registered.
// A write is forwarded to an access to the same bank that follows
// in the next cycle. Per-bank valid bits make an unwritten bank read as its
// reset values, so no clearing pass is needed after reset. Configuration
// writes are taken at any time and are meant to be done while idle.
module gpio_bank_set_clear_registers_top #(
    parameter int NUM_BANKS       = 4,
    parameter int PINS_PER_BANK_P = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gbscr_req_if.sink         i_req,
    gbscr_rsp_if.source       o_rsp,
    gbscr_cfg_if.sink         i_cfg
);
    import gbscr_pkg::*;

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int P      = PINS_PER_BANK_P;

    typedef logic [NUM_REGS-1:0][P-1:0] t_entry;

    // configuration
    logic r_wide_stride;
    logic r_pull_present;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_stride  <= 1'b1;
            r_pull_present <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_WIDE_STRIDE:  r_wide_stride  <= i_cfg.data[0];
                CFG_PULL_PRESENT: r_pull_present <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // decode
    t_dec             dec;
    logic [BANK_W-1:0] rd_idx;

    gbscr_decode #(
        .NUM_BANKS(NUM_BANKS)
    ) u_decode (
        .i_opcode       (i_req.opcode),
        .i_address      (i_req.address),
        .i_wide_stride  (r_wide_stride),
        .i_pull_present (r_pull_present),
        .o_dec          (dec)
    );

    assign rd_idx = dec.oor ? '0 : dec.bank[BANK_W-1:0];

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_fire;
    logic in_fire;

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    // bank memory
    t_entry            mem [NUM_BANKS];
    logic [NUM_BANKS-1:0] r_vld;
    t_entry            r_rd_data;
    logic              r_rd_vld;

    // stage 1
    t_dec              r_s1;
    logic [BANK_W-1:0] r_s1_idx;
    logic [P-1:0]      r_s1_wdata;
    logic [P-1:0]      r_s1_pads;

    // last write, for forwarding
    logic              r_wb_vld;
    logic [BANK_W-1:0] r_wb_idx;
    t_entry            r_wb_data;

    t_entry reset_entry;
    t_entry cur;
    t_entry n_entry;
    logic   do_write;
    t_rsp   n_rsp;
    t_rsp   r_rsp;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data  <= mem[rd_idx];
            r_rd_vld   <= r_vld[rd_idx];
            r_s1       <= dec;
            r_s1_idx   <= rd_idx;
            r_s1_wdata <= i_req.write_data[P-1:0];
            r_s1_pads  <= i_req.pad_levels[P-1:0];
        end
        if (do_write) begin
            mem[r_s1_idx] <= n_entry;
        end
    end

    always_comb begin
        reset_entry           = '0;
        reset_entry[REG_MASK] = '1;
        reset_entry[REG_PAT1] = '1;
    end

    always_comb begin
        if (r_wb_vld && r_wb_idx == r_s1_idx) begin
            cur = r_wb_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = reset_entry;
        end

        n_entry = cur;
        case (r_s1.op)
            OP_SET:   n_entry[r_s1.sel] = cur[r_s1.sel] | r_s1_wdata;
            OP_CLEAR: n_entry[r_s1.sel] = cur[r_s1.sel] & ~r_s1_wdata;
            default:  ;
        endcase

        do_write = s1_fire && (r_s1.op == OP_SET || r_s1.op == OP_CLEAR);
    end

    always_comb begin
        n_rsp             = '0;
        n_rsp.bank_index  = r_s1.bank[1:0];
        n_rsp.bad_address = (r_s1.op == OP_BAD);
        case (r_s1.op)
            OP_READ_PADS: n_rsp.read_data = DATA_W'(r_s1_pads);
            OP_READ_REG:  n_rsp.read_data = DATA_W'(cur[r_s1.sel]);
            default:      n_rsp.read_data = '0;
        endcase
        if (!r_s1.oor) begin
            n_rsp.output_enable_mask  = DATA_W'(~n_entry[REG_INT] & n_entry[REG_MASK]
                                                & ~n_entry[REG_PAT1]);
            n_rsp.output_level_mask   = DATA_W'(n_entry[REG_PAT0]);
            n_rsp.device_mode_mask    = DATA_W'(~n_entry[REG_INT] & ~n_entry[REG_MASK]);
            n_rsp.interrupt_mode_mask = DATA_W'(n_entry[REG_INT]);
            if (r_pull_present) begin
                n_rsp.pull_up_mask   = DATA_W'(n_entry[REG_PULL_UP]);
                n_rsp.pull_down_mask = DATA_W'(n_entry[REG_PULL_DN]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_wb_vld    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_write) begin
                r_vld[r_s1_idx] <= 1'b1;
                r_wb_vld        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_wb_idx  <= r_s1_idx;
            r_wb_data <= n_entry;
        end
        if (s1_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.read_data           = r_rsp.read_data;
    assign o_rsp.bad_address         = r_rsp.bad_address;
    assign o_rsp.bank_index          = r_rsp.bank_index;
    assign o_rsp.output_enable_mask  = r_rsp.output_enable_mask;
    assign o_rsp.output_level_mask   = r_rsp.output_level_mask;
    assign o_rsp.device_mode_mask    = r_rsp.device_mode_mask;
    assign o_rsp.interrupt_mode_mask = r_rsp.interrupt_mode_mask;
    assign o_rsp.pull_up_mask        = r_rsp.pull_up_mask;
    assign o_rsp.pull_down_mask      = r_rsp.pull_down_mask;

endmodule

### rtl/gbscr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbscr_checker
// Port-level checks of the register block, bound to the top level.
// ----------------------------------------------------------------------------
module gbscr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_read_data,
    input logic        i_bad_address,
    input logic [31:0] i_oe_mask,
    input logic [31:0] i_dm_mask,
    input logic [31:0] i_im_mask
);

    // a bad access never returns data
    a_bad_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_bad_address) |-> (i_read_data == '0))
        else $error("bad access returned nonzero read data");

    // output, device and interrupt modes are exclusive per pin
    a_modes_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_oe_mask & i_dm_mask) == '0
                         && (i_im_mask & (i_oe_mask | i_dm_mask)) == '0))
        else $error("pin modes overlap");

    // a beat taken while the response side keeps ready is answered with a valid response
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) ##1 i_rsp_ready |=> i_rsp_valid)
        else $error("response missing after accepted beat");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_read_data)
                                            && $stable(i_bad_address)))
        else $error("stalled response changed");

endmodule

bind gpio_bank_set_clear_registers_top gbscr_checker u_gbscr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_read_data   (o_rsp.read_data),
    .i_bad_address (o_rsp.bad_address),
    .i_oe_mask     (o_rsp.output_enable_mask),
    .i_dm_mask     (o_rsp.device_mode_mask),
    .i_im_mask     (o_rsp.interrupt_mode_mask)
);
